// ===== design/scss_pkg.sv =====
package scss_pkg;

  localparam int unsigned MaxLenDefault     = 4096;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned OffW              = 12;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPipe  = 8'h7C;

  typedef logic [OffW-1:0] off_t;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_BLANK,
    CC_GT,
    CC_LT,
    CC_PIPE,
    CC_AMP,
    CC_SEMI,
    CC_QUOTE,
    CC_TERM
  } cls_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_AND  = 3'd1,
    OP_OR   = 3'd2,
    OP_BG   = 3'd3,
    OP_PIPE = 3'd4,
    OP_NEXT = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_APPEND = 3'd1,
    RD_OUT    = 3'd2,
    RD_IN     = 3'd3,
    RD_INOUT  = 3'd4
  } redir_e;

  typedef struct packed {
    cls_e cls;
    off_t pos;
  } item_t;

  function automatic cls_e classify(logic [7:0] ch, logic term);
    cls_e c;
    c = CC_OTHER;
    if (term || ch == ChNul) begin
      c = CC_TERM;
    end else if (ch == ChSpace || ch == ChTab) begin
      c = CC_BLANK;
    end else if (ch == ChGt) begin
      c = CC_GT;
    end else if (ch == ChLt) begin
      c = CC_LT;
    end else if (ch == ChPipe) begin
      c = CC_PIPE;
    end else if (ch == ChAmp) begin
      c = CC_AMP;
    end else if (ch == ChSemi) begin
      c = CC_SEMI;
    end else if (ch == ChQuote) begin
      c = CC_QUOTE;
    end
    return c;
  endfunction

endpackage

// ===== design/scss_if.sv =====
interface scss_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       terminator;

  modport source (output valid, output character, output terminator, input ready);
  modport sink (input valid, input character, input terminator, output ready);
endinterface

interface scss_item_if;
  logic            valid;
  logic            ready;
  scss_pkg::item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface scss_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] cmd_first;
  logic [11:0] cmd_end;
  logic [11:0] arg_first;
  logic [11:0] arg_end;
  logic [2:0]  rd_kind;
  logic [11:0] rd_first;
  logic [11:0] rd_end;
  logic [2:0]  operator;
  logic        last_of_run;

  modport source (
    output valid, output cmd_first, output cmd_end, output arg_first,
    output arg_end, output rd_kind, output rd_first, output rd_end,
    output operator, output last_of_run, input ready
  );
  modport sink (
    input valid, input cmd_first, input cmd_end, input arg_first,
    input arg_end, input rd_kind, input rd_first, input rd_end,
    input operator, input last_of_run, output ready
  );
endinterface

// ===== design/shell_command_segment_splitter.sv =====
// Splits a command line, fed one byte per transfer and closed by a terminator
// item (terminator set or byte 0), into segments and returns one result per
// segment: command word, parameter span, redirection kind and target, and the
// closing control operator; offsets count from the line start and stop at
// MaxLen-1. Input bytes are taken one per cycle, while the queue has room, into a
// QueueDepth-entry queue, and the scanner consumes one queued byte per cycle while
// the result side keeps up. A byte that closes two segments at once (a semicolon
// right after a single & or |, or a terminator after one) holds the scanner while
// its second result waits in a spare slot for the single output register. A byte
// is written into the queue register and then scanned into the output register,
// from which its result is shown.
module shell_command_segment_splitter #(
  parameter int unsigned MaxLen     = scss_pkg::MaxLenDefault,
  parameter int unsigned QueueDepth = scss_pkg::QueueDepthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  scss_char_if.sink  char_i,
  scss_res_if.source res_o
);

  scss_item_if front_ch ();
  scss_item_if back_ch ();

  scss_front #(
    .MaxLen (MaxLen)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (char_i),
    .item_o (front_ch)
  );

  scss_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (front_ch),
    .rd_o   (back_ch)
  );

  scss_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (back_ch),
    .res_o  (res_o)
  );

endmodule

// ===== design/scss_front.sv =====
module scss_front #(
  parameter int unsigned MaxLen = scss_pkg::MaxLenDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  scss_char_if.sink   chr_i,
  scss_item_if.source item_o
);

  localparam int unsigned     PosW   = $clog2(MaxLen);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxLen - 1);

  logic [PosW-1:0] pos_q, pos_d;
  scss_pkg::cls_e  cls;
  logic            acc;

  assign cls          = scss_pkg::classify(chr_i.character, chr_i.terminator);
  assign item_o.valid = chr_i.valid;
  assign chr_i.ready  = item_o.ready;
  assign item_o.item  = '{cls: cls, pos: scss_pkg::off_t'(pos_q)};
  assign acc          = chr_i.valid && item_o.ready;

  // restart at each line end, hold at the last offset on long lines
  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      if (cls == scss_pkg::CC_TERM) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== design/scss_fifo.sv =====
module scss_fifo #(
  parameter int unsigned Depth = scss_pkg::QueueDepthDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  scss_item_if.sink   wr_i,
  scss_item_if.source rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  scss_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_i.ready = (cnt_q != CntW'(Depth));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.item  = mem_q[rptr_q];
  assign push       = wr_i.valid && wr_i.ready;
  assign pop        = rd_o.valid && rd_o.ready;

  always_comb begin
    wptr_d = push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/scss_back.sv =====
module scss_back (
  input logic        clk_i,
  input logic        rst_ni,
  scss_item_if.sink  item_i,
  scss_res_if.source res_o
);

  typedef enum logic [10:0] {
    PH_SEEK_CMD     = 11'b000_0000_0001,
    PH_CMD          = 11'b000_0000_0010,
    PH_GAP_FIRST    = 11'b000_0000_0100,
    PH_PARAM        = 11'b000_0000_1000,
    PH_GAP_MORE     = 11'b000_0001_0000,
    PH_REDIR_OP     = 11'b000_0010_0000,
    PH_SEEK_TARGET  = 11'b000_0100_0000,
    PH_TARGET       = 11'b000_1000_0000,
    PH_AFTER_TARGET = 11'b001_0000_0000,
    PH_OP_PENDING   = 11'b010_0000_0000,
    PH_IGNORE       = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic             in_quote;
    logic             pend_or;
    scss_pkg::off_t   cmd_b;
    scss_pkg::off_t   cmd_e;
    scss_pkg::off_t   par_b;
    scss_pkg::off_t   par_e;
    scss_pkg::redir_e rkind;
    scss_pkg::off_t   rd_b;
    scss_pkg::off_t   rd_e;
  } seg_t;

  typedef struct packed {
    scss_pkg::off_t   cmd_first;
    scss_pkg::off_t   cmd_end;
    scss_pkg::off_t   arg_first;
    scss_pkg::off_t   arg_end;
    scss_pkg::redir_e rd_kind;
    scss_pkg::off_t   rd_first;
    scss_pkg::off_t   rd_end;
    scss_pkg::op_e    operator;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    seg_t seg;
    logic emit;
    res_t res;
  } step_t;

  function automatic seg_t seg_clear();
    seg_t s;
    s       = '0;
    s.phase = PH_SEEK_CMD;
    return s;
  endfunction

  function automatic res_t make_res(seg_t s, scss_pkg::op_e op);
    res_t r;
    r.cmd_first   = s.cmd_b;
    r.cmd_end     = s.cmd_e;
    r.arg_first   = s.par_b;
    r.arg_end     = s.par_e;
    r.rd_kind     = s.rkind;
    r.rd_first    = s.rd_b;
    r.rd_end      = s.rd_e;
    r.operator    = op;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic is_word(scss_pkg::cls_e c);
    return c == scss_pkg::CC_OTHER || c == scss_pkg::CC_QUOTE;
  endfunction

  function automatic step_t do_emit(seg_t s, scss_pkg::op_e op);
    step_t t;
    t.seg  = seg_clear();
    t.emit = 1'b1;
    t.res  = make_res(s, op);
    return t;
  endfunction

  function automatic step_t take_op(seg_t s, scss_pkg::cls_e c);
    step_t t;
    t.seg  = s;
    t.emit = 1'b0;
    t.res  = make_res(s, scss_pkg::OP_NONE);
    unique case (c)
      scss_pkg::CC_AMP: begin
        t.seg.pend_or = 1'b0;
        t.seg.phase   = PH_OP_PENDING;
      end
      scss_pkg::CC_PIPE: begin
        t.seg.pend_or = 1'b1;
        t.seg.phase   = PH_OP_PENDING;
      end
      scss_pkg::CC_SEMI: begin
        t = do_emit(s, scss_pkg::OP_NEXT);
      end
      default: begin
        // stray word or redirection sign after the target: close the segment, drop the rest
        t           = do_emit(s, scss_pkg::OP_NONE);
        t.seg.phase = PH_IGNORE;
      end
    endcase
    return t;
  endfunction

  function automatic step_t end_words(seg_t s, scss_pkg::cls_e c);
    step_t t;
    t.seg  = s;
    t.emit = 1'b0;
    t.res  = make_res(s, scss_pkg::OP_NONE);
    unique case (c)
      scss_pkg::CC_GT: begin
        t.seg.rkind = scss_pkg::RD_OUT;
        t.seg.phase = PH_REDIR_OP;
      end
      scss_pkg::CC_LT: begin
        t.seg.rkind = scss_pkg::RD_IN;
        t.seg.phase = PH_REDIR_OP;
      end
      default: begin
        t = take_op(s, c);
      end
    endcase
    return t;
  endfunction

  function automatic step_t step_plain(seg_t s, scss_pkg::cls_e c, scss_pkg::off_t pos);
    step_t t;
    logic  stays;
    logic  q;
    t.seg  = s;
    t.emit = 1'b0;
    t.res  = make_res(s, scss_pkg::OP_NONE);
    stays  = s.in_quote || is_word(c);
    q      = s.in_quote ? (c != scss_pkg::CC_QUOTE) : (c == scss_pkg::CC_QUOTE);
    unique case (s.phase)
      PH_SEEK_CMD: begin
        if (is_word(c)) begin
          t.seg.cmd_b    = pos;
          t.seg.in_quote = (c == scss_pkg::CC_QUOTE);
          t.seg.phase    = PH_CMD;
        end else if (c != scss_pkg::CC_BLANK) begin
          t = end_words(s, c);
        end
      end
      PH_CMD: begin
        if (stays) begin
          t.seg.in_quote = q;
        end else begin
          t.seg.cmd_e = pos;
          if (c == scss_pkg::CC_BLANK) begin
            t.seg.phase = PH_GAP_FIRST;
          end else begin
            t = end_words(t.seg, c);
          end
        end
      end
      PH_GAP_FIRST, PH_GAP_MORE: begin
        if (is_word(c)) begin
          if (s.phase == PH_GAP_FIRST) begin
            t.seg.par_b = pos;
          end
          t.seg.in_quote = (c == scss_pkg::CC_QUOTE);
          t.seg.phase    = PH_PARAM;
        end else if (c != scss_pkg::CC_BLANK) begin
          t = end_words(s, c);
        end
      end
      PH_PARAM: begin
        if (stays) begin
          t.seg.in_quote = q;
        end else begin
          t.seg.par_e = pos;
          if (c == scss_pkg::CC_BLANK) begin
            t.seg.phase = PH_GAP_MORE;
          end else begin
            t = end_words(t.seg, c);
          end
        end
      end
      PH_SEEK_TARGET: begin
        if (is_word(c)) begin
          t.seg.rd_b     = pos;
          t.seg.in_quote = (c == scss_pkg::CC_QUOTE);
          t.seg.phase    = PH_TARGET;
        end else if (c != scss_pkg::CC_BLANK) begin
          t = take_op(s, c);
        end
      end
      PH_TARGET: begin
        if (stays) begin
          t.seg.in_quote = q;
        end else begin
          t.seg.rd_e = pos;
          if (c == scss_pkg::CC_BLANK) begin
            t.seg.phase = PH_AFTER_TARGET;
          end else begin
            t = take_op(t.seg, c);
          end
        end
      end
      PH_AFTER_TARGET: begin
        if (c != scss_pkg::CC_BLANK) begin
          t = take_op(s, c);
        end
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  seg_t            seg_q, seg_d, seg_nx, plain_in, term_seg;
  step_t           st;
  res_t            r0, r1, out_q, out_d, hold_q, hold_d;
  logic            e0, e1;
  logic            out_v_q, out_v_d, hold_v_q, hold_v_d;
  logic            out_free, pop;
  scss_pkg::cls_e  cls;
  scss_pkg::off_t  pos;
  scss_pkg::op_e   single_op;

  assign cls       = item_i.item.cls;
  assign pos       = item_i.item.pos;
  assign single_op = seg_q.pend_or ? scss_pkg::OP_PIPE : scss_pkg::OP_BG;

  // a pending single operator closes the segment before the byte is rescanned;
  // after a lone redirection sign the byte is rescanned as target search
  always_comb begin
    plain_in = seg_q;
    if (seg_q.phase == PH_OP_PENDING) begin
      plain_in = seg_clear();
    end else if (seg_q.phase == PH_REDIR_OP) begin
      plain_in.phase = PH_SEEK_TARGET;
    end
  end

  assign st = step_plain(plain_in, cls, pos);

  always_comb begin
    term_seg = seg_q;
    unique case (seg_q.phase)
      PH_CMD:    term_seg.cmd_e = pos;
      PH_PARAM:  term_seg.par_e = pos;
      PH_TARGET: term_seg.rd_e  = pos;
      default: begin
      end
    endcase
  end

  always_comb begin
    seg_nx = st.seg;
    e0     = st.emit;
    e1     = 1'b0;
    r0     = st.res;
    r1     = st.res;
    if (cls == scss_pkg::CC_TERM) begin
      seg_nx = seg_clear();
      e0     = 1'b0;
      if (seg_q.phase == PH_OP_PENDING) begin
        e0 = 1'b1;
        e1 = 1'b1;
        r0 = make_res(term_seg, single_op);
        r1 = make_res(seg_clear(), scss_pkg::OP_NONE);
      end else if (seg_q.phase != PH_IGNORE) begin
        e0 = 1'b1;
        r0 = make_res(term_seg, scss_pkg::OP_NONE);
      end
    end else if (seg_q.phase == PH_OP_PENDING) begin
      if (!seg_q.pend_or && cls == scss_pkg::CC_AMP) begin
        seg_nx = seg_clear();
        e0     = 1'b1;
        r0     = make_res(seg_q, scss_pkg::OP_AND);
      end else if (seg_q.pend_or && cls == scss_pkg::CC_PIPE) begin
        seg_nx = seg_clear();
        e0     = 1'b1;
        r0     = make_res(seg_q, scss_pkg::OP_OR);
      end else begin
        e0 = 1'b1;
        r0 = make_res(seg_q, single_op);
        e1 = st.emit;
        r1 = st.res;
      end
    end else if (seg_q.phase == PH_REDIR_OP && cls == scss_pkg::CC_GT) begin
      seg_nx       = seg_q;
      e0           = 1'b0;
      seg_nx.phase = PH_SEEK_TARGET;
      seg_nx.rkind = (seg_q.rkind == scss_pkg::RD_OUT) ? scss_pkg::RD_APPEND
                                                        : scss_pkg::RD_INOUT;
    end
    r0.last_of_run = !e1;
    r1.last_of_run = 1'b1;
  end

  // output register plus one spare slot for the second result of an item
  assign out_free     = !out_v_q || res_o.ready;
  assign item_i.ready = !hold_v_q && out_free;
  assign pop          = item_i.valid && item_i.ready;

  always_comb begin
    seg_d    = seg_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !res_o.ready;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    if (hold_v_q && out_free) begin
      out_d    = hold_q;
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end else if (pop) begin
      seg_d = seg_nx;
      if (e0) begin
        out_d   = r0;
        out_v_d = 1'b1;
      end
      if (e1) begin
        hold_d   = r1;
        hold_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= seg_clear();
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      seg_q    <= seg_d;
      out_v_q  <= out_v_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign res_o.valid       = out_v_q;
  assign res_o.cmd_first   = out_q.cmd_first;
  assign res_o.cmd_end     = out_q.cmd_end;
  assign res_o.arg_first   = out_q.arg_first;
  assign res_o.arg_end     = out_q.arg_end;
  assign res_o.rd_kind     = out_q.rd_kind;
  assign res_o.rd_first    = out_q.rd_first;
  assign res_o.rd_end      = out_q.rd_end;
  assign res_o.operator    = out_q.operator;
  assign res_o.last_of_run = out_q.last_of_run;

  a_first_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.last_of_run) |-> hold_v_q)
    else $error("non-final result shown without a second one waiting");

  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (out_v_q && hold_q.last_of_run))
    else $error("spare result slot out of order");

  a_quote_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q.in_quote |-> (seg_q.phase == PH_CMD || seg_q.phase == PH_PARAM ||
                        seg_q.phase == PH_TARGET))
    else $error("quote flag set outside a word");

  a_ignore_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q.phase == PH_IGNORE) |-> (seg_q.cmd_b == '0 && seg_q.par_b == '0 &&
                                    seg_q.rd_b == '0 && seg_q.rkind == scss_pkg::RD_NONE))
    else $error("segment not cleared while skipping rest of line");

endmodule

// ===== tb/sv/tb_shell_command_segment_splitter.sv =====
module tb_shell_command_segment_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import scss_pkg::*;

  localparam int unsigned LineMax   = MaxLenDefault;
  localparam int unsigned CycleCap  = 300000;
  localparam int unsigned RandItems = 550;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_AMP  = 2'd1;
  localparam logic [1:0] PEND_BAR  = 2'd2;

  typedef enum logic [3:0] {
    SEEK_CMD, IN_CMD, GAP_FIRST, IN_PARAM, GAP_MORE, REDIR_OP,
    SEEK_TARGET, IN_TARGET, AFTER_TARGET, OP_PENDING, SKIP_REST
  } scan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } byte_item_t;

  typedef struct packed {
    off_t   cmd_first;
    off_t   cmd_end;
    off_t   arg_first;
    off_t   arg_end;
    redir_e rd_kind;
    off_t   rd_first;
    off_t   rd_end;
    op_e    operator;
    logic   last_of_run;
  } segment_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       ch_valid = 1'b0;
  logic [7:0] ch_byte  = 8'h00;
  logic       ch_term  = 1'b0;
  logic       res_rdy  = 1'b0;

  scss_char_if ch_if ();
  scss_res_if  res_if ();

  assign ch_if.valid      = ch_valid;
  assign ch_if.character  = ch_byte;
  assign ch_if.terminator = ch_term;
  assign res_if.ready     = res_rdy;

  shell_command_segment_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (ch_if),
    .res_o  (res_if)
  );

  byte_item_t  line_q[$];
  segment_t    segment_q[$];
  int unsigned n_sent  = 0;
  int unsigned n_total = 1;
  int unsigned n_err   = 0;
  int unsigned n_cycle = 0;

  // Scanner state mirrored from the block
  int unsigned ln_pos = 0;
  scan_e       ph     = SEEK_CMD;
  logic        quoted = 1'b0;
  logic [1:0]  pend   = PEND_NONE;
  segment_t    cur    = '0;
  segment_t    out_buf[2];
  int          n_out;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Line parser

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return is_blank(c) || c == ChGt || c == ChLt || c == ChPipe || c == ChAmp ||
           c == ChSemi;
  endfunction

  // True while the byte belongs to the current word; tracks quoting.
  function automatic logic word_byte(logic [7:0] c);
    if (quoted) begin
      if (c == ChQuote) quoted = 1'b0;
      return 1'b1;
    end
    if (c == ChQuote) begin
      quoted = 1'b1;
      return 1'b1;
    end
    return !is_sep(c);
  endfunction

  task automatic clear_segment();
    ph     = SEEK_CMD;
    quoted = 1'b0;
    pend   = PEND_NONE;
    cur    = '0;
  endtask

  task automatic close_segment(op_e op);
    if (n_out < 2) begin
      cur.operator   = op;
      out_buf[n_out] = cur;
      n_out++;
    end
    clear_segment();
  endtask

  task automatic take_operator(logic [7:0] c);
    if (c == ChAmp) begin
      pend = PEND_AMP;
      ph   = OP_PENDING;
    end else if (c == ChPipe) begin
      pend = PEND_BAR;
      ph   = OP_PENDING;
    end else if (c == ChSemi) begin
      close_segment(OP_NEXT);
    end else begin
      close_segment(OP_NONE);
      ph = SKIP_REST;
    end
  endtask

  task automatic end_of_words(logic [7:0] c);
    if (c == ChGt) begin
      cur.rd_kind = RD_OUT;
      ph = REDIR_OP;
    end else if (c == ChLt) begin
      cur.rd_kind = RD_IN;
      ph = REDIR_OP;
    end else begin
      take_operator(c);
    end
  endtask

  task automatic scan_byte(logic [7:0] c, off_t pos);
    logic again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ph)
        SEEK_CMD: begin
          if (!is_blank(c)) begin
            if (!is_sep(c)) begin
              cur.cmd_first = pos;
              quoted = (c == ChQuote);
              ph = IN_CMD;
            end else begin
              end_of_words(c);
            end
          end
        end
        IN_CMD: begin
          if (!word_byte(c)) begin
            cur.cmd_end = pos;
            if (is_blank(c)) ph = GAP_FIRST;
            else end_of_words(c);
          end
        end
        GAP_FIRST, GAP_MORE: begin
          if (!is_blank(c)) begin
            if (!is_sep(c)) begin
              if (ph == GAP_FIRST) cur.arg_first = pos;
              quoted = (c == ChQuote);
              ph = IN_PARAM;
            end else begin
              end_of_words(c);
            end
          end
        end
        IN_PARAM: begin
          if (!word_byte(c)) begin
            cur.arg_end = pos;
            if (is_blank(c)) ph = GAP_MORE;
            else end_of_words(c);
          end
        end
        REDIR_OP: begin
          ph = SEEK_TARGET;
          if (c == ChGt) begin
            cur.rd_kind = (cur.rd_kind == RD_OUT) ? RD_APPEND : RD_INOUT;
          end else begin
            again = 1'b1;
          end
        end
        SEEK_TARGET: begin
          if (!is_blank(c)) begin
            if (!is_sep(c)) begin
              cur.rd_first = pos;
              quoted = (c == ChQuote);
              ph = IN_TARGET;
            end else begin
              take_operator(c);
            end
          end
        end
        IN_TARGET: begin
          if (!word_byte(c)) begin
            cur.rd_end = pos;
            if (is_blank(c)) ph = AFTER_TARGET;
            else take_operator(c);
          end
        end
        AFTER_TARGET: begin
          if (!is_blank(c)) take_operator(c);
        end
        OP_PENDING: begin
          if (pend == PEND_AMP && c == ChAmp) begin
            close_segment(OP_AND);
          end else if (pend == PEND_BAR && c == ChPipe) begin
            close_segment(OP_OR);
          end else begin
            // single operator: close it, then rescan this byte as a new segment
            close_segment((pend == PEND_BAR) ? OP_PIPE : OP_BG);
            again = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic predict_segments(logic [7:0] c, logic term);
    off_t pos;
    pos   = off_t'(ln_pos);
    n_out = 0;
    if (term || c == ChNul) begin
      case (ph)
        IN_CMD:    cur.cmd_end = pos;
        IN_PARAM:  cur.arg_end = pos;
        IN_TARGET: cur.rd_end  = pos;
        default: begin
        end
      endcase
      if (ph == OP_PENDING) begin
        close_segment((pend == PEND_BAR) ? OP_PIPE : OP_BG);
        close_segment(OP_NONE);
      end else if (ph != SKIP_REST) begin
        close_segment(OP_NONE);
      end
      ln_pos = 0;
      clear_segment();
    end else begin
      scan_byte(c, pos);
      if (ln_pos < LineMax - 1) ln_pos++;
    end
    for (int i = 0; i < n_out; i++) begin
      out_buf[i].last_of_run = (i == n_out - 1);
      segment_q.push_back(out_buf[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus

  task automatic push_char(logic [7:0] c);
    line_q.push_back('{ch: c, term: 1'b0});
  endtask

  task automatic push_str(string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  // Close the line either by the terminator flag or by a zero byte.
  task automatic end_line();
    if ($urandom_range(1) == 0) line_q.push_back('{ch: 8'($urandom_range(255)), term: 1'b1});
    else line_q.push_back('{ch: ChNul, term: 1'b0});
  endtask

  function automatic logic [7:0] rand_special();
    case ($urandom_range(8))
      0: return ChSpace;
      1: return ChTab;
      2: return ChGt;
      3: return ChLt;
      4: return ChPipe;
      5: return ChAmp;
      6: return ChSemi;
      7: return ChQuote;
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  task automatic add_blanks(int lo, int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) push_char(($urandom_range(1) == 0) ? ChSpace : ChTab);
  endtask

  task automatic add_word();
    int n;
    int r;
    n = $urandom_range(5, 1);
    repeat (n) begin
      r = $urandom_range(19);
      if (r == 0) begin
        push_char(ChQuote);
        repeat ($urandom_range(3)) push_char(rand_special());
        // leave some quotes open to the end of the line
        if ($urandom_range(4) != 0) push_char(ChQuote);
      end else if (r == 1) begin
        push_char(8'($urandom_range(255, 1)));
      end else begin
        push_char(8'("a" + $urandom_range(25)));
      end
    end
  endtask

  task automatic add_line();
    int nseg;
    nseg = $urandom_range(3, 1);
    for (int s = 0; s < nseg; s++) begin
      add_blanks(0, 2);
      if ($urandom_range(7) != 0) add_word();
      repeat ($urandom_range(3)) begin
        add_blanks(1, 2);
        add_word();
      end
      if ($urandom_range(2) == 0) begin
        add_blanks(0, 1);
        case ($urandom_range(3))
          0: push_str(">>");
          1: push_str(">");
          2: push_str("<");
          default: push_str("<>");
        endcase
        add_blanks(0, 2);
        if ($urandom_range(4) != 0) add_word();
        if ($urandom_range(5) == 0) begin
          add_blanks(1, 1);
          add_word();
        end
      end
      add_blanks(0, 1);
      if (s < nseg - 1 || $urandom_range(1) == 0) begin
        case ($urandom_range(4))
          0: push_str("&&");
          1: push_str("||");
          2: push_str("&");
          3: push_str("|");
          default: push_str(";");
        endcase
      end
    end
    end_line();
  endtask

  function automatic int unsigned idle_pct(logic rx);
    case (n_sent * 3 / n_total)
      0: return rx ? 49 : 28;
      1: return rx ? 28 : 49;
      default: return 0;
    endcase
  endfunction

  initial begin
    int unsigned base;

    // append, and-and, tab as a blank
    push_str("a\tb>>c&&d");
    line_q.push_back('{ch: 8'hFF, term: 1'b1});
    // in-out, single pipe followed by semicolon
    push_str("<>e|;");
    push_char(ChNul);
    // top byte value, word after the target drops the rest of the line
    push_char(8'hFF);
    push_str(">g h&");
    line_q.push_back('{ch: ChNul, term: 1'b1});
    // quoted separator, or-or, background pending at end of line
    push_str("\"|\"||i&");
    line_q.push_back('{ch: 8'h00, term: 1'b1});

    base = line_q.size();
    while (line_q.size() - base < RandItems) begin
      if ($urandom_range(99) < 85) begin
        add_line();
      end else begin
        repeat ($urandom_range(12, 1)) begin
          push_char(($urandom_range(1) == 0) ? rand_special() : 8'($urandom_range(255, 1)));
        end
        end_line();
      end
    end
    n_total = line_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (line_q.size() != 0 || ch_valid) @(negedge clk_i);
    while (segment_q.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb_shell_command_segment_splitter: done, clean");
    end else begin
      $display("tb_shell_command_segment_splitter: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver

  always @(posedge clk_i or negedge rst_ni) begin
    byte_item_t nxt;
    if (!rst_ni) begin
      ch_valid <= 1'b0;
      ch_byte  <= 8'h00;
      ch_term  <= 1'b0;
    end else begin
      if (ch_valid && ch_if.ready) n_sent <= n_sent + 1;
      // advance only when the current transfer is done or nothing is offered
      if (!ch_valid || ch_if.ready) begin
        if (line_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = line_q.pop_front();
          ch_valid <= 1'b1;
          ch_byte  <= nxt.ch;
          ch_term  <= nxt.term;
        end else begin
          ch_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t want;
    if (!rst_ni) begin
      res_rdy <= 1'b0;
    end else begin
      n_cycle++;
      if (ch_valid && ch_if.ready) predict_segments(ch_byte, ch_term);
      if (res_if.valid && res_rdy) begin
        if (segment_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cmd %0d..%0d op %0d",
                   $time, res_if.cmd_first, res_if.cmd_end, res_if.operator);
          n_err++;
        end else begin
          want = segment_q.pop_front();
          check_field("cmd_first", want.cmd_first, res_if.cmd_first);
          check_field("cmd_end", want.cmd_end, res_if.cmd_end);
          check_field("arg_first", want.arg_first, res_if.arg_first);
          check_field("arg_end", want.arg_end, res_if.arg_end);
          check_field("rd_kind", want.rd_kind, res_if.rd_kind);
          check_field("rd_first", want.rd_first, res_if.rd_first);
          check_field("rd_end", want.rd_end, res_if.rd_end);
          check_field("operator", want.operator, res_if.operator);
          check_field("last_of_run", want.last_of_run, res_if.last_of_run);
        end
      end
      res_rdy <= ($urandom_range(99) >= idle_pct(1'b1));
      if (n_cycle == CycleCap) begin
        $display("%0t: timeout with %0d results outstanding", $time, segment_q.size());
        $display("tb_shell_command_segment_splitter: done, errors");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
design/scss_pkg.sv
design/scss_if.sv
design/scss_front.sv
design/scss_fifo.sv
design/scss_back.sv
design/shell_command_segment_splitter.sv
tb/sv/tb_shell_command_segment_splitter.sv
